[sv/oms_pkg.sv]
// Package for the one-mismatch substring search block.
// Holds parameter defaults, field widths and item mode codes.
// No dependencies.
`default_nettype none

package oms_pkg;

    localparam int MAX_PATTERN_DEF = 64;
    localparam longint unsigned MAX_TEXT_DEF = 64'd1048576;

    localparam int MODE_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int START_W = 20;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_PATTERN = 2'd1,
        MODE_TEXT    = 2'd2
    } mode_t;

    // saturating mismatch count: 0, 1, or two-or-more
    typedef logic [1:0] mcnt_t;
    localparam mcnt_t MCNT_SAT = 2'd2;

endpackage

`default_nettype wire

[sv/one_mismatch_substring_search.sv]
// Top level of the one-mismatch substring search block.
// Uses oms_pkg for defaults, widths and mode codes.
// Input register, one row of per-offset mismatch cells, result register.
`default_nettype none

// Searches streamed text for the first window that differs from a loaded
// pattern in at most one byte. Send a clear, then pattern bytes, then text
// bytes. One transaction is taken every cycle unless a result waits on the
// m_ side; a result is written to the result register as the text byte
// that causes it leaves the input register. The row of MAX_PATTERN
// mismatch cells all update in parallel for every text byte. At most one
// result is given per search: found with its start index, or not-found on
// the byte marked last. Further text is ignored until the next clear.
module one_mismatch_substring_search #(
    parameter int              MAX_PATTERN = oms_pkg::MAX_PATTERN_DEF,
    parameter longint unsigned MAX_TEXT    = oms_pkg::MAX_TEXT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [oms_pkg::S_TDATA_W-1:0] s_tdata,  // mode[1:0], char_value[9:2]
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [oms_pkg::M_TDATA_W-1:0]      m_tdata,  // start_index[19:0]
    output logic [0:0]                         m_tuser   // found[0]
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int POS_W = $clog2(MAX_TEXT + 64'd1);
    localparam int SW    = (POS_W > oms_pkg::START_W) ? POS_W : oms_pkg::START_W;

    // input register
    logic                          in_valid_reg;
    logic [oms_pkg::MODE_W-1:0]    in_mode_reg;
    logic [oms_pkg::CHAR_W-1:0]    in_char_reg;
    logic                          in_last_reg;

    // search state
    logic [oms_pkg::CHAR_W-1:0]    pat_reg [MAX_PATTERN];
    oms_pkg::mcnt_t                cnt_reg [MAX_PATTERN];
    oms_pkg::mcnt_t                cnt_next[MAX_PATTERN];
    logic [LEN_W-1:0]              len_reg;
    logic [POS_W-1:0]              pos_reg;
    logic                          done_reg;

    // result register
    logic                          out_valid_reg;
    logic                          out_found_reg;
    logic [oms_pkg::START_W-1:0]   out_start_reg;

    logic                          advance;
    logic                          text_act;
    logic                          in_bound;
    logic [LEN_W-1:0]              lenm1;
    logic [SW-1:0]                 pos_ext;
    logic [SW-1:0]                 start_full;
    logic                          win_ready;
    oms_pkg::mcnt_t                tail_cnt;
    logic                          hit;
    logic                          emit;
    logic                          emit_found;
    logic [oms_pkg::START_W-1:0]   emit_start;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {{(oms_pkg::M_TDATA_W - oms_pkg::START_W){1'b0}}, out_start_reg};

    assign in_bound   = pos_reg < POS_W'(MAX_TEXT);
    assign text_act   = in_valid_reg && (in_mode_reg == oms_pkg::MODE_TEXT) && !done_reg;
    assign lenm1      = len_reg - LEN_W'(1);
    assign pos_ext    = SW'(pos_reg);
    assign start_full = pos_ext - SW'(lenm1);
    assign win_ready  = pos_ext >= SW'(lenm1);

    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            oms_pkg::mcnt_t prev;
            prev = (k == 0) ? 2'd0 : cnt_reg[(k == 0) ? 0 : k - 1];
            if ((pat_reg[k] != in_char_reg) && (prev != oms_pkg::MCNT_SAT)) begin
                cnt_next[k] = prev + 2'd1;
            end else begin
                cnt_next[k] = prev;
            end
        end
    end

    assign tail_cnt = cnt_next[lenm1[IDX_W-1:0]];

    always_comb begin
        hit        = 1'b0;
        emit_start = '0;
        if (in_bound) begin
            if (len_reg == '0) begin
                hit = 1'b1;
            end else if (win_ready && (tail_cnt != oms_pkg::MCNT_SAT)) begin
                hit        = 1'b1;
                emit_start = start_full[oms_pkg::START_W-1:0];
            end
        end
        emit       = text_act && (hit || in_last_reg);
        emit_found = hit;
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_mode_reg <= s_tdata[oms_pkg::MODE_W-1:0];
            in_char_reg <= s_tdata[oms_pkg::MODE_W +: oms_pkg::CHAR_W];
            in_last_reg <= s_tlast;
        end
    end

    // pattern bytes, no reset
    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg && (in_mode_reg == oms_pkg::MODE_PATTERN) && !done_reg
            && (pos_reg == '0) && (len_reg < LEN_W'(MAX_PATTERN))) begin
            pat_reg[len_reg[IDX_W-1:0]] <= in_char_reg;
        end
    end

    // search state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            pos_reg       <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_PATTERN; k++) begin
                cnt_reg[k] <= '0;
            end
        end else if (advance) begin
            out_valid_reg <= emit;
            if (emit) begin
                out_found_reg <= emit_found;
                out_start_reg <= emit_start;
                done_reg      <= 1'b1;
            end
            if (in_valid_reg) begin
                case (in_mode_reg)
                    oms_pkg::MODE_CLEAR: begin
                        len_reg  <= '0;
                        pos_reg  <= '0;
                        done_reg <= 1'b0;
                        for (int k = 0; k < MAX_PATTERN; k++) begin
                            cnt_reg[k] <= '0;
                        end
                    end
                    oms_pkg::MODE_PATTERN: begin
                        if (!done_reg && (pos_reg == '0) && (len_reg < LEN_W'(MAX_PATTERN))) begin
                            len_reg <= len_reg + LEN_W'(1);
                        end
                    end
                    oms_pkg::MODE_TEXT: begin
                        if (!done_reg && in_bound) begin
                            pos_reg <= pos_reg + POS_W'(1);
                            if (len_reg != '0) begin
                                for (int k = 0; k < MAX_PATTERN; k++) begin
                                    cnt_reg[k] <= cnt_next[k];
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

[verif/oms_search_checker.sv]
`timescale 1ns / 100ps
// Checker for the one-mismatch substring search block: it watches both stream channels.
// It predicts the search outcome and compares every result transaction.
// Depends on oms_pkg for widths, mode codes and the mismatch saturation value.

module oms_search_checker
    import oms_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tlast,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic [0:0]           m_tuser,
    output int                        fault_count,
    output int                        results_due
);

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start;
    } search_result_t;

    logic [CHAR_W-1:0] pat_bytes [MAX_PATTERN_DEF];
    logic [6:0]        pat_len;
    mcnt_t             win_miss [MAX_PATTERN_DEF];
    longint unsigned   text_pos;
    logic              search_over;
    search_result_t    due_results [$];
    search_result_t    seen;
    search_result_t    want;

    function automatic void clear_search();
        foreach (win_miss[i]) win_miss[i] = '0;
        pat_len     = '0;
        text_pos    = 0;
        search_over = 1'b0;
    endfunction

    function automatic void post_result(input logic hit, input logic [START_W-1:0] at);
        due_results.push_back({hit, at});
        search_over = 1'b1;
    endfunction

    // one accepted input transaction
    function automatic void advance_search(input logic [MODE_W-1:0] code,
                                           input logic [CHAR_W-1:0] ch,
                                           input logic lst);
        longint unsigned    p;
        longint unsigned    a;
        longint unsigned    k;
        longint unsigned    kmax;
        mcnt_t              cnt;
        logic               hit;
        logic [START_W-1:0] hit_at;
        hit    = 1'b0;
        hit_at = '0;
        case (code)
            MODE_CLEAR: begin
                clear_search();
            end
            MODE_PATTERN: begin
                if (!search_over && text_pos == 0 && pat_len < MAX_PATTERN_DEF) begin
                    pat_bytes[pat_len] = ch;
                    pat_len++;
                end
            end
            MODE_TEXT: begin
                if (!search_over) begin
                    if (text_pos < MAX_TEXT_DEF) begin
                        p = text_pos;
                        text_pos++;
                        if (pat_len == 0) begin
                            hit = 1'b1;
                        end else begin
                            kmax = (p < pat_len - 1) ? p : pat_len - 1;
                            for (k = 0; k <= kmax; k++) begin
                                a   = p - k;
                                cnt = (k == 0) ? mcnt_t'(0) : win_miss[a % MAX_PATTERN_DEF];
                                if (pat_bytes[k] != ch && cnt < MCNT_SAT) cnt++;
                                win_miss[a % MAX_PATTERN_DEF] = cnt;
                                if (k == pat_len - 1 && cnt <= 1) begin
                                    hit    = 1'b1;
                                    hit_at = a[START_W-1:0];
                                end
                            end
                        end
                    end
                    if (hit) post_result(1'b1, hit_at);
                    else if (lst) post_result(1'b0, '0);
                end
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_search();
            due_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                seen = {m_tuser[0], m_tdata[START_W-1:0]};
                if (due_results.size() == 0) begin
                    fault_count++;
                    $error("unexpected result transaction: found %0d start_index %0d",
                           seen.found, seen.start);
                end else begin
                    want = due_results.pop_front();
                    if (seen.found !== want.found) begin
                        fault_count++;
                        $error("found: expected %0d, actual %0d", want.found, seen.found);
                    end
                    if (seen.start !== want.start) begin
                        fault_count++;
                        $error("start_index: expected %0d, actual %0d", want.start, seen.start);
                    end
                end
            end
            if (s_tvalid && s_tready) advance_search(s_tdata[MODE_W-1:0],
                                                     s_tdata[MODE_W+CHAR_W-1:MODE_W], s_tlast);
        end
        results_due = due_results.size();
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// Top of the testbench for one_mismatch_substring_search: clock, reset, stimulus, verdict.
// Instantiates the block and oms_search_checker; depends on oms_pkg.

module testbench;
    import oms_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int ITEM_TARGET = 1350;
    localparam int STALL_LIMIT = 2000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    int                   fault_count;
    int                   results_due;
    logic                 calm = 1'b0;
    int                   items_sent = 0;
    int                   ready_hold = 0;

    one_mismatch_substring_search u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    oms_search_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fault_count (fault_count),
        .results_due (results_due)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // mostly short idles, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready   <= 1'b1;
            ready_hold = calm ? 0 : idle_len();
        end
    end

    // called and returns at a falling edge
    task automatic send(input logic [MODE_W-1:0] code, input logic [CHAR_W-1:0] ch,
                        input logic lst);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-CHAR_W-MODE_W){1'b0}}, ch, code};
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // one search: clear, pattern, text with a planted near match most of the time
    task automatic run_search();
        logic [CHAR_W-1:0] pat [$];
        logic [CHAR_W-1:0] txt [$];
        logic [CHAR_W-1:0] base;
        logic [CHAR_W-1:0] alpha;
        int                plen;
        int                tlen;
        int                sel;
        int                at;
        int                flips;
        int                end_at;
        logic              drop_last;
        calm  = ($urandom_range(0, 3) == 0);
        sel   = $urandom_range(0, 99);
        base  = 8'($urandom);
        alpha = ($urandom_range(0, 3) == 0) ? 8'hff : 8'h03;
        if (sel < 3) plen = 0;
        else if (sel < 8) plen = $urandom_range(60, 66);
        else if (sel < 20) plen = $urandom_range(9, 20);
        else plen = $urandom_range(1, 8);
        for (int i = 0; i < plen; i++) pat.push_back(base ^ (8'($urandom) & alpha));
        tlen = plen + $urandom_range(0, 10);
        if (plen > 1 && $urandom_range(0, 9) == 0) tlen = $urandom_range(1, plen - 1);
        if (tlen == 0) tlen = 1;
        for (int i = 0; i < tlen; i++) txt.push_back(base ^ (8'($urandom) & alpha));
        if (plen > 0 && tlen >= plen && $urandom_range(0, 9) < 7) begin
            at = $urandom_range(0, tlen - plen);
            for (int i = 0; i < plen; i++) txt[at + i] = pat[i];
            flips = $urandom_range(0, 2);
            repeat (flips) txt[at + $urandom_range(0, plen - 1)] ^= 8'($urandom_range(1, 255));
        end
        end_at    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, tlen - 1) : tlen - 1;
        drop_last = ($urandom_range(0, 19) == 0);

        send(MODE_CLEAR, 8'($urandom), 1'($urandom));
        foreach (pat[i]) send(MODE_PATTERN, pat[i], 1'($urandom));
        for (int i = 0; i < tlen; i++) begin
            if ($urandom_range(0, 29) == 0) send(MODE_SPARE, 8'($urandom), 1'($urandom));
            if (i == 1 && $urandom_range(0, 7) == 0)
                send(MODE_PATTERN, 8'($urandom), 1'($urandom));
            send(MODE_TEXT, txt[i], (i == end_at) && !drop_last);
        end
        items_sent += 1 + plen + tlen;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty pattern, then everything ignored once done
        send(MODE_CLEAR, 8'hff, 1'b1);
        send(MODE_TEXT, 8'h00, 1'b0);
        send(MODE_TEXT, 8'hff, 1'b1);
        send(MODE_PATTERN, 8'h5a, 1'b0);
        send(MODE_SPARE, 8'hff, 1'b1);
        // exact match closing on the byte marked last
        send(MODE_CLEAR, 8'h00, 1'b0);
        send(MODE_PATTERN, 8'h00, 1'b1);
        send(MODE_PATTERN, 8'hff, 1'b0);
        send(MODE_PATTERN, 8'h80, 1'b0);
        send(MODE_SPARE, 8'h00, 1'b0);
        send(MODE_TEXT, 8'hff, 1'b0);
        send(MODE_TEXT, 8'h00, 1'b0);
        send(MODE_TEXT, 8'hff, 1'b0);
        send(MODE_TEXT, 8'h80, 1'b1);
        // pattern longer than text, late pattern byte ignored
        send(MODE_CLEAR, 8'h00, 1'b0);
        send(MODE_PATTERN, 8'h11, 1'b0);
        send(MODE_PATTERN, 8'h22, 1'b0);
        send(MODE_PATTERN, 8'h33, 1'b0);
        send(MODE_TEXT, 8'h11, 1'b0);
        send(MODE_PATTERN, 8'h44, 1'b0);
        send(MODE_TEXT, 8'h22, 1'b1);
        // single mismatch at the second start
        send(MODE_CLEAR, 8'h00, 1'b0);
        send(MODE_PATTERN, 8'haa, 1'b0);
        send(MODE_PATTERN, 8'h55, 1'b0);
        send(MODE_TEXT, 8'h00, 1'b0);
        send(MODE_TEXT, 8'haa, 1'b0);
        send(MODE_TEXT, 8'h54, 1'b1);

        while (items_sent < ITEM_TARGET) run_search();
        s_tvalid <= 1'b0;

        while (results_due != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fault_count == 0 && results_due == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("testbench: done, errors");
        $finish;
    end

endmodule

[filelist.f]
sv/oms_pkg.sv
sv/one_mismatch_substring_search.sv
verif/oms_search_checker.sv
verif/testbench.sv
